### hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int PRIO_W    = 8;
  localparam int PAYLOAD_W = 16;
  localparam int COUNT_W   = 4;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } spq_action_t;

  // Broadcast to every cell in the row for one transfer.
  typedef struct packed {
    logic                 insert;
    logic                 remove;
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
  } spq_cell_ctrl_t;

  typedef struct packed {
    logic                 accepted;
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
    logic                 full;
    logic                 empty;
  } spq_result_t;

endpackage

### hw/rtl/spq_cell.sv
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::spq_cell_ctrl_t      ctrl,
  input  logic                         occupied,
  input  logic                         keep_prev,
  input  logic [spq_pkg::PRIO_W-1:0]    prio_prev,
  input  logic [spq_pkg::PAYLOAD_W-1:0] payload_prev,
  input  logic [spq_pkg::PRIO_W-1:0]    prio_below,
  input  logic [spq_pkg::PAYLOAD_W-1:0] payload_below,
  output logic                         keep,
  output logic [spq_pkg::PRIO_W-1:0]    prio,
  output logic [spq_pkg::PAYLOAD_W-1:0] payload
);
  import spq_pkg::*;

  // An occupied cell at or above the new priority stays where it is on insert.
  assign keep = occupied && (prio >= ctrl.prio);

  always_ff @(posedge clk) begin
    if (ctrl.insert && !keep) begin
      if (keep_prev) begin
        prio    <= ctrl.prio;
        payload <= ctrl.payload;
      end else begin
        prio    <= prio_prev;
        payload <= payload_prev;
      end
    end else if (ctrl.remove) begin
      prio    <= prio_below;
      payload <= payload_below;
    end
  end

endmodule

### hw/rtl/spq_out_buf.sv
module spq_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  spq_pkg::spq_result_t push_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output spq_pkg::spq_result_t out_data,
  output logic                 skid_full
);
  import spq_pkg::*;

  spq_result_t skid_data;
  logic        advance;

  // The output register is free when empty or being taken this cycle.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (advance) begin
      out_valid <= skid_full || push;
      skid_full <= skid_full && push;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (skid_full) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### hw/rtl/sorted_priority_queue_core.sv
// Bounded priority queue of DEPTH entries, kept sorted in a row of cells with
// the highest priority in the first cell. An insert places the new entry below
// every held entry of greater or equal priority, so among equal priorities the
// older entry leaves first; a remove returns the first cell and shifts the row
// up. One transfer is taken per cycle while in_stall is low: every cell
// compares its priority with the new one and moves in the same cycle, and the
// result is registered in the output register, or in the one-entry skid stage
// behind it while the output stalls, so input keeps flowing while a result
// waits; input stalls only once the skid stage holds a result too.
// Inserts into a full queue and removes from an empty one are answered with
// accepted low and the state untouched. The count output carries the low four
// bits of the occupancy.
module sorted_priority_queue_core #(
  parameter int DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
  input  logic [spq_pkg::PAYLOAD_W-1:0] payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [spq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spq_pkg::PAYLOAD_W-1:0] out_payload,
  output logic [spq_pkg::COUNT_W-1:0]   count,
  output logic                          full_res,
  output logic                          empty_res
);
  import spq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0]     occ;
  logic [OCC_W-1:0]     occ_next;
  logic                 transfer;
  logic                 is_full;
  logic                 is_empty;
  logic                 do_insert;
  logic                 do_remove;
  spq_cell_ctrl_t       ctrl;
  spq_result_t          result;
  spq_result_t          out_data;

  logic [DEPTH-1:0]     cell_keep;
  logic [PRIO_W-1:0]    cell_prio    [DEPTH];
  logic [PAYLOAD_W-1:0] cell_payload [DEPTH];

  assign transfer  = in_valid && !in_stall;
  assign is_full   = (occ == OCC_W'(DEPTH));
  assign is_empty  = (occ == '0);
  assign do_insert = transfer && (spq_action_t'(action) == ACT_INSERT) && !is_full;
  assign do_remove = transfer && (spq_action_t'(action) == ACT_REMOVE) && !is_empty;

  assign ctrl.insert  = do_insert;
  assign ctrl.remove  = do_remove;
  assign ctrl.prio    = priority_req;
  assign ctrl.payload = payload;

  always_comb begin
    occ_next = occ;
    if (do_insert) begin
      occ_next = occ + OCC_W'(1);
    end else if (do_remove) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // The row of cells. The first cell takes the new entry whenever it does not
  // keep its own; the last cell holds on a remove, since no cell lies below it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 keep_prev;
    logic [PRIO_W-1:0]    prio_prev;
    logic [PAYLOAD_W-1:0] payload_prev;
    logic [PRIO_W-1:0]    prio_below;
    logic [PAYLOAD_W-1:0] payload_below;

    if (i == 0) begin : g_first
      assign keep_prev    = 1'b1;
      assign prio_prev    = priority_req;
      assign payload_prev = payload;
    end else begin : g_inner
      assign keep_prev    = cell_keep[i-1];
      assign prio_prev    = cell_prio[i-1];
      assign payload_prev = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign prio_below    = cell_prio[i];
      assign payload_below = cell_payload[i];
    end else begin : g_below
      assign prio_below    = cell_prio[i+1];
      assign payload_below = cell_payload[i+1];
    end

    spq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occupied      (OCC_W'(i) < occ),
      .keep_prev     (keep_prev),
      .prio_prev     (prio_prev),
      .payload_prev  (payload_prev),
      .prio_below    (prio_below),
      .payload_below (payload_below),
      .keep          (cell_keep[i]),
      .prio          (cell_prio[i]),
      .payload       (cell_payload[i])
    );
  end

  // A removed entry is read from the first cell before the row shifts.
  always_comb begin
    result.accepted = do_insert || do_remove;
    result.prio     = do_remove ? cell_prio[0]    : '0;
    result.payload  = do_remove ? cell_payload[0] : '0;
    result.count    = COUNT_W'(occ_next);
    result.full     = (occ_next == OCC_W'(DEPTH));
    result.empty    = (occ_next == '0);
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (transfer),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (in_stall)
  );

  assign accepted     = out_data.accepted;
  assign out_priority = out_data.prio;
  assign out_payload  = out_data.payload;
  assign count        = out_data.count;
  assign full_res     = out_data.full;
  assign empty_res    = out_data.empty;

  // The occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy above capacity");

  // An insert into a queue with room grows it by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (transfer && (spq_action_t'(action) == ACT_INSERT) && !is_full)
    |=> (occ == $past(occ) + OCC_W'(1)))
    else $error("insert did not grow occupancy");

  // The skid stage only holds a result while the output register holds one.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid stage full with output register empty");

  // A result never reports a queue that is full and empty at once.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(full_res && empty_res))
    else $error("result flags full and empty together");

endmodule
